>>> design/ycc420_pkg.sv
// ---------------------------------------------------------------------------
// ycc420_pkg: shared types and constants for the RGB to YCbCr 4:2:0 encoder
// Beat payload structs, JFIF fixed-point weights and default sizes.
// ---------------------------------------------------------------------------
package ycc420_pkg;

    // Configuration register
    localparam int unsigned CFG_W       = 12;
    localparam int unsigned WIDTH_RESET = 640;
    localparam int unsigned MIN_WIDTH   = 2;

    // Default sizes
    localparam int unsigned MAX_WIDTH_DEF = 2048;
    localparam int unsigned QUEUE_DEPTH   = 4;

    // JFIF weights, 16-bit fractions
    localparam logic [15:0] Y_R_WT = 16'd19595;
    localparam logic [15:0] Y_G_WT = 16'd38470;
    localparam logic [15:0] Y_B_WT = 16'd7471;
    localparam logic [15:0] CB_WT  = 16'd36962;
    localparam logic [15:0] CR_WT  = 16'd46727;
    localparam logic [7:0]  CHROMA_OFS = 8'd128;

    // Input beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } rgb_in_t;

    // Result beat
    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
    } ycc_out_t;

    // Position of a pixel within its 2x2 block
    typedef struct packed {
        logic col_odd;
        logic odd_row;
    } pix_tag_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        pix_tag_t   tag;
    } pix_job_t;

endpackage

>>> design/rgb_to_ycbcr420_encoder.sv
// ---------------------------------------------------------------------------
// rgb_to_ycbcr420_encoder: RGB to JFIF YCbCr with 2x2 chroma subsampling
// Path: an accepted beat goes through the queue, the three compute stages and the output register.
// Throughput: one beat per cycle while m_ready does not stall the pipeline and fill the queue.
// Reset (aresetn, synchronous, low): width 640, row 0 column 0, queue and
//   pipeline empty; the chroma line store is not cleared.
// ---------------------------------------------------------------------------
module rgb_to_ycbcr420_encoder #(
    parameter int unsigned MAX_WIDTH = ycc420_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ycc420_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ycc420_pkg::rgb_in_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ycc420_pkg::ycc_out_t         m_data
);

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned QW         = $bits(ycc420_pkg::pix_job_t) + ADDR_W;

    logic                 q_push, q_pop, q_full, q_empty;
    ycc420_pkg::pix_job_t front_job, back_job;
    logic [ADDR_W-1:0]    front_addr, back_addr;
    logic [QW-1:0]        q_wdata, q_rdata;

    // position tracking and classification
    ycc420_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (front_job),
        .q_addr      (front_addr)
    );

    assign q_wdata = {front_job, front_addr};

    // decoupling queue
    ycc420_queue #(
        .WIDTH (QW),
        .DEPTH (ycc420_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    assign back_job  = q_rdata[QW-1:ADDR_W];
    assign back_addr = q_rdata[ADDR_W-1:0];

    // conversion and chroma averaging
    ycc420_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_job   (back_job),
        .q_addr  (back_addr),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> design/ycc420_ram.sv
// ---------------------------------------------------------------------------
// ycc420_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ycc420_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ycc420_queue.sv
// ---------------------------------------------------------------------------
// ycc420_queue: short flop-based FIFO between front and back
// Lets the classifier and the color pipeline stall independently.
// ---------------------------------------------------------------------------
module ycc420_queue #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = ycc420_pkg::QUEUE_DEPTH,
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue underflow");
`endif

endmodule

>>> design/ycc420_front.sv
// ---------------------------------------------------------------------------
// ycc420_front: input side, raster position tracking
// Holds the line width register, tracks column and row parity and tags
// each accepted beat with its place in the 2x2 block and its line slot.
// ---------------------------------------------------------------------------
module ycc420_front #(
    parameter int unsigned MAX_WIDTH = ycc420_pkg::MAX_WIDTH_DEF,
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH),
    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2,
    localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    localparam int unsigned CW = ((ycc420_pkg::CFG_W > COL_W) ? ycc420_pkg::CFG_W : COL_W) + 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ycc420_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ycc420_pkg::rgb_in_t            s_data,
    input  logic                           q_full,
    output logic                           q_push,
    output ycc420_pkg::pix_job_t           q_job,
    output logic [ADDR_W-1:0]              q_addr
);

    logic [ycc420_pkg::CFG_W-1:0] width_reg;
    logic [COL_W-1:0]             col_reg, col_next;
    logic                         odd_row_reg, odd_row_next;

    logic [CW-1:0]    width_raw;
    logic [CW-1:0]    width_eff;
    logic [COL_W-1:0] col_cur;
    logic             odd_cur;
    logic [CW-1:0]    col_inc;
    logic [COL_W-1:0] pair_idx;
    logic [COL_W-1:0] pair_wrap;
    logic             accept;

    // width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= ycc420_pkg::CFG_W'(ycc420_pkg::WIDTH_RESET);
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    assign s_ready = !q_full && aresetn;
    assign accept  = s_valid && s_ready;

    // clamp width, advance position
    always_comb begin
        width_raw = CW'(width_reg);
        if (width_raw < CW'(ycc420_pkg::MIN_WIDTH)) begin
            width_eff = CW'(ycc420_pkg::MIN_WIDTH);
        end else if (width_raw > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end

        col_cur = s_data.frame_start ? '0 : col_reg;
        odd_cur = s_data.frame_start ? 1'b0 : odd_row_reg;
        col_inc = CW'(col_cur) + CW'(1);

        if (col_inc >= width_eff) begin
            col_next     = '0;
            odd_row_next = !odd_cur;
        end else begin
            col_next     = col_inc[COL_W-1:0];
            odd_row_next = odd_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            odd_row_reg <= 1'b0;
        end else if (accept) begin
            col_reg     <= col_next;
            odd_row_reg <= odd_row_next;
        end
    end

    // line slot of the pair, folded into the store depth
    always_comb begin
        pair_idx = col_cur >> 1;
        if (pair_idx >= COL_W'(LINE_DEPTH)) begin
            pair_wrap = pair_idx - COL_W'(LINE_DEPTH);
        end else begin
            pair_wrap = pair_idx;
        end
    end

    assign q_push              = accept;
    assign q_addr              = pair_wrap[ADDR_W-1:0];
    assign q_job.red           = s_data.red;
    assign q_job.green         = s_data.green;
    assign q_job.blue          = s_data.blue;
    assign q_job.tag.col_odd   = col_cur[0];
    assign q_job.tag.odd_row   = odd_cur;

endmodule

>>> design/ycc420_back.sv
// ---------------------------------------------------------------------------
// ycc420_back: color conversion and 2x2 chroma averaging pipeline
// Three compute stages and an output register, with the chroma line store.
// ---------------------------------------------------------------------------
module ycc420_back #(
    parameter int unsigned MAX_WIDTH = ycc420_pkg::MAX_WIDTH_DEF,
    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2,
    localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  ycc420_pkg::pix_job_t  q_job,
    input  logic [ADDR_W-1:0]     q_addr,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ycc420_pkg::ycc_out_t  m_data
);

    localparam int unsigned ENTRY_W = 18;

    logic en;

    // stage 1: luma products
    logic                   s1_valid_reg;
    ycc420_pkg::pix_tag_t   s1_tag_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [7:0]             s1_red_reg, s1_blue_reg;
    logic [23:0]            s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic [23:0]            pr_next, pg_next, pb_next;

    // stage 2: luma and color differences
    logic                   s2_valid_reg;
    ycc420_pkg::pix_tag_t   s2_tag_reg;
    logic [ADDR_W-1:0]      s2_addr_reg;
    logic [7:0]             s2_luma_reg;
    logic signed [8:0]      s2_db_reg, s2_dr_reg;
    logic [23:0]            y_sum;
    logic [7:0]             luma_next;
    logic signed [8:0]      db_next, dr_next;

    // stage 3: chroma of this pixel
    logic                   s3_valid_reg;
    ycc420_pkg::pix_tag_t   s3_tag_reg;
    logic [ADDR_W-1:0]      s3_addr_reg;
    logic [7:0]             s3_luma_reg;
    logic [7:0]             s3_cb_reg, s3_cr_reg;
    logic signed [24:0]     cb_prod, cr_prod;
    logic [7:0]             cb_next, cr_next;

    // pair state and output
    logic [15:0]            pair_partial_reg;
    logic                   m_valid_reg;
    ycc420_pkg::ycc_out_t   m_data_reg, m_data_next;
    logic [8:0]             cb_pair, cr_pair;
    logic [9:0]             cb_quad, cr_quad;

    // line store
    logic                   ram_we, ram_re;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    // stage 1 datapath
    assign pr_next = 24'(ycc420_pkg::Y_R_WT) * 24'(q_job.red);
    assign pg_next = 24'(ycc420_pkg::Y_G_WT) * 24'(q_job.green);
    assign pb_next = 24'(ycc420_pkg::Y_B_WT) * 24'(q_job.blue);

    // stage 2 datapath
    assign y_sum     = s1_pr_reg + s1_pg_reg + s1_pb_reg;
    assign luma_next = y_sum[23:16];
    assign db_next   = $signed({1'b0, s1_blue_reg}) - $signed({1'b0, luma_next});
    assign dr_next   = $signed({1'b0, s1_red_reg}) - $signed({1'b0, luma_next});

    // stage 3 datapath: floor(w*d / 65536) + 128, kept mod 256
    assign cb_prod = $signed({9'd0, ycc420_pkg::CB_WT}) * $signed({{16{s2_db_reg[8]}}, s2_db_reg});
    assign cr_prod = $signed({9'd0, ycc420_pkg::CR_WT}) * $signed({{16{s2_dr_reg[8]}}, s2_dr_reg});
    assign cb_next = cb_prod[23:16] + ycc420_pkg::CHROMA_OFS;
    assign cr_next = cr_prod[23:16] + ycc420_pkg::CHROMA_OFS;

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg  <= q_job.tag;
            s1_addr_reg <= q_addr;
            s1_red_reg  <= q_job.red;
            s1_blue_reg <= q_job.blue;
            s1_pr_reg   <= pr_next;
            s1_pg_reg   <= pg_next;
            s1_pb_reg   <= pb_next;

            s2_tag_reg  <= s1_tag_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_luma_reg <= luma_next;
            s2_db_reg   <= db_next;
            s2_dr_reg   <= dr_next;

            s3_tag_reg  <= s2_tag_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_luma_reg <= s2_luma_reg;
            s3_cb_reg   <= cb_next;
            s3_cr_reg   <= cr_next;

            if (s3_valid_reg) begin
                m_data_reg <= m_data_next;
            end
        end
    end

    // even pixel of a pair parks its chroma
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_partial_reg <= '0;
        end else if (en && s3_valid_reg && !s3_tag_reg.col_odd) begin
            pair_partial_reg <= {s3_cb_reg, s3_cr_reg};
        end
    end

    // pair sums, line store access and block average
    always_comb begin
        cb_pair = {1'b0, pair_partial_reg[15:8]} + {1'b0, s3_cb_reg};
        cr_pair = {1'b0, pair_partial_reg[7:0]} + {1'b0, s3_cr_reg};
        cb_quad = {1'b0, cb_pair} + {1'b0, ram_rdata[17:9]};
        cr_quad = {1'b0, cr_pair} + {1'b0, ram_rdata[8:0]};

        m_data_next.luma         = s3_luma_reg;
        m_data_next.chroma_valid = 1'b0;
        m_data_next.blue_diff    = '0;
        m_data_next.red_diff     = '0;
        if (s3_tag_reg.col_odd && s3_tag_reg.odd_row) begin
            m_data_next.chroma_valid = 1'b1;
            m_data_next.blue_diff    = cb_quad[9:2];
            m_data_next.red_diff     = cr_quad[9:2];
        end
    end

    assign ram_wdata = {cb_pair, cr_pair};
    assign ram_we    = en && s3_valid_reg && s3_tag_reg.col_odd && !s3_tag_reg.odd_row;
    assign ram_re    = en && s2_valid_reg && s2_tag_reg.col_odd && s2_tag_reg.odd_row;

    ycc420_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s3_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (s2_addr_reg),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (s3_addr_reg != s2_addr_reg))
        else $error("line store read and write hit the same slot");
    a_diff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.chroma_valid) |-> (m_data.blue_diff == '0 && m_data.red_diff == '0))
        else $error("chroma fields set without chroma_valid");
`endif

endmodule
